// ===== design/mppt_pkg.sv =====
// ----------------------------------------------------------------------------
// MPPT duty controller package
// Shared types, command codes, register indexes and power scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mppt_pkg;

  // Command codes carried with each input item.
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAX_VOLTAGE = 2'd0,
    REG_MAX_CURRENT = 2'd1,
    REG_MIN_DUTY    = 2'd2,
    REG_MAX_DUTY    = 2'd3
  } reg_idx_t;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned POWER_W = 23;
  localparam int unsigned PROD_W  = 32;

  // Unsigned 32-bit divide by 1000: multiply by this reciprocal, shift by 38.
  localparam int unsigned          MAGIC_W   = 29;
  localparam logic [MAGIC_W-1:0]   DIV_MAGIC = 29'd274877907;
  localparam int unsigned          DIV_SHIFT = 38;
  localparam int unsigned          RECIP_W   = PROD_W + MAGIC_W;

  // Signed value wide enough for a 16-bit count stepped by one either way.
  localparam int unsigned STEP_W = FIELD_W + 2;
  typedef logic signed [STEP_W-1:0] step_t;

  // Stage load enables for the power pipeline.
  typedef struct packed {
    logic load_prod;
    logic load_power;
  } pwr_ctl_t;

  // Clamp to [lo, hi]; when lo is above hi, values below lo give lo and all others give hi.
  function automatic logic [FIELD_W-1:0] clamp_count(step_t v, logic [FIELD_W-1:0] lo,
                                                     logic [FIELD_W-1:0] hi);
    step_t lo_s;
    step_t hi_s;
    logic [FIELD_W-1:0] res;
    lo_s = step_t'({2'b00, lo});
    hi_s = step_t'({2'b00, hi});
    if (v < lo_s) begin
      res = lo;
    end else if (v > hi_s) begin
      res = hi;
    end else begin
      res = v[FIELD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/mppt_pwr.sv =====
// ----------------------------------------------------------------------------
// MPPT power pipeline
// Two registered stages: voltage times current, then divide by 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module mppt_pwr
  import mppt_pkg::*;
(
  input  wire logic               clk,
  input  wire pwr_ctl_t           ctl,
  input  wire logic [FIELD_W-1:0] volt,
  input  wire logic [FIELD_W-1:0] curr,
  output logic      [POWER_W-1:0] power
);

  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic [RECIP_W-1:0] recip;
  logic [POWER_W-1:0] power_r;
  logic [POWER_W-1:0] power_nxt;

  // Product in milliwatts times 1000; fits 32 bits for all inputs.
  assign prod_nxt = PROD_W'(volt) * PROD_W'(curr);

  // Reciprocal multiply gives the exact truncated quotient by 1000.
  assign recip     = RECIP_W'(prod_r) * RECIP_W'(DIV_MAGIC);
  assign power_nxt = recip[DIV_SHIFT +: POWER_W];

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_r <= prod_nxt;
    end
    if (ctl.load_power) begin
      power_r <= power_nxt;
    end
  end

  assign power = power_r;

endmodule

`default_nettype wire

// ===== design/mppt_perturb_observe_duty.sv =====
// ----------------------------------------------------------------------------
// Perturb-and-observe MPPT duty controller
// Buck converter PWM compare count control with voltage and current limits.
// ----------------------------------------------------------------------------
// Each input transfer is a command: sample, start or stop, and gives exactly
// one result transfer. The block is a four-stage pipeline (input register,
// 16x16 power multiply, reciprocal divide by 1000, state update into the
// output register), and a new item is accepted every cycle while the output
// side keeps up. Stages with no item collapse, so a stalled output does not
// block the input until the pipeline is full. Configuration writes are taken
// at once and are meant to be issued while no item is in flight; writing a
// duty limit clamps the current count to the new limits immediately.
`default_nettype none

module mppt_perturb_observe_duty
  import mppt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0: volt_mv[15:0], curr_ma[15:0],
  // start_duty_count[15:0].
  input  wire logic [47:0] in_tdata,
  // Fields from bit 0: cmd[1:0].
  input  wire logic [1:0]  in_tuser,
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0: duty_count[15:0], output_enable, voltage_limited,
  // current_limited, step_up, then four zero bits.
  output logic [23:0]      out_tdata,
  // Configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [FIELD_W-1:0] COUNT_MAX = FIELD_W'((32'd1 << COUNT_WIDTH) - 32'd1);

  // Configuration registers.
  logic [FIELD_W-1:0] max_volt_r;
  logic [FIELD_W-1:0] max_curr_r;
  logic [FIELD_W-1:0] min_duty_r;
  logic [FIELD_W-1:0] max_duty_r;

  // Controller state.
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic                   dir_r;
  logic                   dir_nxt;
  logic [POWER_W-1:0]     prev_power_r;
  logic [POWER_W-1:0]     prev_power_nxt;
  logic                   enable_r;
  logic                   enable_nxt;

  // Pipeline stages.
  logic               a_valid_r;
  logic [1:0]         a_cmd_r;
  logic [FIELD_W-1:0] a_volt_r;
  logic [FIELD_W-1:0] a_curr_r;
  logic [FIELD_W-1:0] a_req_r;

  logic               b_valid_r;
  logic [1:0]         b_cmd_r;
  logic [FIELD_W-1:0] b_req_r;
  logic               b_vlim_r;
  logic               b_ilim_r;

  logic               c_valid_r;
  logic [1:0]         c_cmd_r;
  logic [FIELD_W-1:0] c_req_r;
  logic               c_vlim_r;
  logic               c_ilim_r;

  logic               out_valid_r;
  logic [23:0]        out_data_r;
  logic [23:0]        out_data_nxt;

  logic rdy_a;
  logic rdy_b;
  logic rdy_c;
  logic rdy_d;
  logic retire;

  logic [POWER_W-1:0] power;
  pwr_ctl_t           pwr_ctl;

  logic [FIELD_W-1:0] lo_sat;
  logic [FIELD_W-1:0] hi_sat;
  logic [FIELD_W-1:0] cfg_sat;
  logic [FIELD_W-1:0] count_ext;
  logic [FIELD_W-1:0] clamp_res;
  step_t              step_val;
  logic               vlim_out;
  logic               ilim_out;

  // Stage advance: a stage takes new data when empty or when it moves on.
  // No input transfer is taken while reset is held.
  assign rdy_d     = !out_valid_r || out_tready;
  assign rdy_c     = !c_valid_r || rdy_d;
  assign rdy_b     = !b_valid_r || rdy_c;
  assign rdy_a     = !a_valid_r || rdy_b;
  assign in_tready = rdy_a && rst_n;
  assign retire    = c_valid_r && rdy_d;

  assign pwr_ctl.load_prod  = rdy_b;
  assign pwr_ctl.load_power = rdy_c;

  mppt_pwr u_pwr (
    .clk   (clk),
    .ctl   (pwr_ctl),
    .volt  (a_volt_r),
    .curr  (a_curr_r),
    .power (power)
  );

  // Duty limits saturate to the counter range.
  assign lo_sat    = (min_duty_r > COUNT_MAX) ? COUNT_MAX : min_duty_r;
  assign hi_sat    = (max_duty_r > COUNT_MAX) ? COUNT_MAX : max_duty_r;
  assign cfg_sat   = (cfg_wdata > COUNT_MAX) ? COUNT_MAX : cfg_wdata;
  assign count_ext = FIELD_W'(count_r);

  // Control valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_valid_r <= in_tvalid;
      end
      if (rdy_b) begin
        b_valid_r <= a_valid_r;
      end
      if (rdy_c) begin
        c_valid_r <= b_valid_r;
      end
      if (rdy_d) begin
        out_valid_r <= c_valid_r;
      end
    end
  end

  // Pipeline payload; limit compares happen on the way into stage B.
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_cmd_r  <= in_tuser;
      a_volt_r <= in_tdata[15:0];
      a_curr_r <= in_tdata[31:16];
      a_req_r  <= in_tdata[47:32];
    end
    if (rdy_b) begin
      b_cmd_r  <= a_cmd_r;
      b_req_r  <= a_req_r;
      b_vlim_r <= a_volt_r > max_volt_r;
      b_ilim_r <= a_curr_r > max_curr_r;
    end
    if (rdy_c) begin
      c_cmd_r  <= b_cmd_r;
      c_req_r  <= b_req_r;
      c_vlim_r <= b_vlim_r;
      c_ilim_r <= b_ilim_r;
    end
    if (rdy_d) begin
      out_data_r <= out_data_nxt;
    end
  end

  // State update for the retiring item, or duty clamp on a limit write.
  always_comb begin
    count_nxt      = count_r;
    dir_nxt        = dir_r;
    prev_power_nxt = prev_power_r;
    enable_nxt     = enable_r;
    vlim_out       = 1'b0;
    ilim_out       = 1'b0;
    step_val       = step_t'({2'b00, count_ext});
    clamp_res      = count_ext;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MIN_DUTY: clamp_res = clamp_count(step_val, cfg_sat, hi_sat);
        REG_MAX_DUTY: clamp_res = clamp_count(step_val, lo_sat, cfg_sat);
        default:      clamp_res = count_ext;
      endcase
      count_nxt = clamp_res[COUNT_WIDTH-1:0];
    end else if (retire) begin
      case (c_cmd_r)
        CMD_SAMPLE: begin
          prev_power_nxt = power;
          if (c_vlim_r) begin
            vlim_out = 1'b1;
            step_val = step_val - step_t'(1);
          end else if (c_ilim_r) begin
            ilim_out = 1'b1;
            step_val = step_val - step_t'(1);
          end else begin
            if (prev_power_r > power) begin
              dir_nxt = !dir_r;
            end
            step_val = dir_nxt ? (step_val + step_t'(1)) : (step_val - step_t'(1));
          end
          clamp_res = clamp_count(step_val, lo_sat, hi_sat);
          count_nxt = clamp_res[COUNT_WIDTH-1:0];
        end
        CMD_START: begin
          clamp_res  = clamp_count(step_t'({2'b00, c_req_r}), lo_sat, hi_sat);
          count_nxt  = clamp_res[COUNT_WIDTH-1:0];
          enable_nxt = 1'b1;
        end
        CMD_STOP: begin
          enable_nxt = 1'b0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  assign out_data_nxt = {4'b0000, dir_nxt, ilim_out, vlim_out, enable_nxt,
                         FIELD_W'(count_nxt)};

  // Configuration and controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_volt_r   <= 16'hFFFF;
      max_curr_r   <= 16'hFFFF;
      min_duty_r   <= 16'd0;
      max_duty_r   <= 16'd480;
      count_r      <= '0;
      dir_r        <= 1'b1;
      prev_power_r <= '0;
      enable_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MAX_VOLTAGE: max_volt_r <= cfg_wdata;
          REG_MAX_CURRENT: max_curr_r <= cfg_wdata;
          REG_MIN_DUTY:    min_duty_r <= cfg_wdata;
          REG_MAX_DUTY:    max_duty_r <= cfg_wdata;
          default:         max_volt_r <= max_volt_r;
        endcase
      end
      count_r      <= count_nxt;
      dir_r        <= dir_nxt;
      prev_power_r <= prev_power_nxt;
      enable_r     <= enable_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // With ordered limits the count always sits inside them.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lo_sat <= hi_sat) |-> (count_ext >= lo_sat && count_ext <= hi_sat))
    else $error("duty count outside configured limits");

  // Tracking state moves only when an item retires.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!retire && !cfg_wr_en) |=> ($stable(dir_r) && $stable(prev_power_r)
                                 && $stable(enable_r)))
    else $error("controller state changed without a retiring item");

  // An item in the last stage waits while the output register is held.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && !rdy_d) |=> (c_valid_r && $stable(c_cmd_r)))
    else $error("stage C item lost during output stall");

  // Only one limit flag can be reported for an item.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[17] && out_data_r[18]))
    else $error("voltage and current limit flags both set");
`endif

endmodule

`default_nettype wire
